// ===== design/nrlc_pkg.sv =====
// ----------------------------------------------------------------------------
// nrlc_pkg
// shared widths, register indexes and word types of the nested rectangle
// chain block
// ----------------------------------------------------------------------------
package nrlc_pkg;

  localparam int DIM_W = 20;
  localparam int NUM_W = 16;
  localparam int VAL_W = 16;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_CARD_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_CARD_HEIGHT = 2'd1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [NUM_W-1:0] NUM_MAX = 16'hFFFF;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [NUM_W-1:0] num;
  } rect_t;

  typedef struct packed {
    rect_t r;
    logic  keep;
    logic  fin;
  } qword_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== design/nrlc_front.sv =====
// ----------------------------------------------------------------------------
// nrlc_front
// accepts rectangles, numbers them and checks them against the card
// ----------------------------------------------------------------------------
module nrlc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  nrlc_pkg::qstat_t               qstat,
  input  logic [nrlc_pkg::DIM_W-1:0]     rect_width,
  input  logic [nrlc_pkg::DIM_W-1:0]     rect_height,
  input  logic                           final_item,
  input  logic                           cfg_valid,
  input  logic [nrlc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [nrlc_pkg::DIM_W-1:0]     cfg_data,
  output logic                           q_we,
  output nrlc_pkg::qword_t               q_word
);

  logic [nrlc_pkg::DIM_W-1:0] card_w;
  logic [nrlc_pkg::DIM_W-1:0] card_h;
  logic [nrlc_pkg::NUM_W-1:0] arrival;
  logic [nrlc_pkg::NUM_W-1:0] arrival_next;

  assign q_we = push && !qstat.full;
  // saturating arrival number
  assign arrival_next = (arrival == nrlc_pkg::NUM_MAX) ? arrival
                                                       : arrival + 1'b1;

  always_comb begin
    q_word.r.w   = rect_width;
    q_word.r.h   = rect_height;
    q_word.r.num = arrival_next;
    q_word.keep  = (rect_width > card_w) && (rect_height > card_h);
    q_word.fin   = final_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      card_w  <= '0;
      card_h  <= '0;
      arrival <= '0;
    end else begin
      if (cfg_valid && cfg_index == nrlc_pkg::REG_CARD_WIDTH) card_w <= cfg_data;
      if (cfg_valid && cfg_index == nrlc_pkg::REG_CARD_HEIGHT) card_h <= cfg_data;
      if (q_we) arrival <= final_item ? '0 : arrival_next;
    end
  end

endmodule

// ===== design/nrlc_fifo.sv =====
// ----------------------------------------------------------------------------
// nrlc_fifo
// short word queue between the front and the back
// ----------------------------------------------------------------------------
module nrlc_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  nrlc_pkg::qword_t  wdata,
  input  logic              re,
  output nrlc_pkg::qword_t  rdata,
  output nrlc_pkg::qstat_t  stat
);

  nrlc_pkg::qword_t              mem [nrlc_pkg::QDEPTH];
  logic [nrlc_pkg::QPTR_W-1:0]   wptr;
  logic [nrlc_pkg::QPTR_W-1:0]   rptr;
  logic [nrlc_pkg::QCNT_W-1:0]   cnt;

  assign rdata      = mem[rptr];
  assign stat.full  = (cnt == nrlc_pkg::QCNT_W'(nrlc_pkg::QDEPTH));
  assign stat.empty = (cnt == '0);

  always_ff @(posedge clk) begin
    if (we) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (we) wptr <= wptr + 1'b1;
      if (re) rptr <= rptr + 1'b1;
      if (we && !re) cnt <= cnt + 1'b1;
      else if (re && !we) cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== design/nrlc_back.sv =====
// ----------------------------------------------------------------------------
// nrlc_back
// sorted store, chain search, chain walk and result output
// ----------------------------------------------------------------------------
module nrlc_back #(
  parameter int MAX_RECTS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  nrlc_pkg::qstat_t               qstat,
  input  nrlc_pkg::qword_t               q_word,
  output logic                           q_re,
  output logic                           empty,
  input  logic                           pop,
  output logic [nrlc_pkg::VAL_W-1:0]     value,
  output logic                           is_length,
  output logic                           run_end,
  output logic                           overflowed
);

  localparam int AW = $clog2(MAX_RECTS);
  localparam int CW = $clog2(MAX_RECTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_DP_RDP, S_DP_LATP, S_DP_CMP,
    S_WK_SET, S_WK_RD, S_WK_WR, S_EM_LEN, S_EM_RD, S_EM_WR
  } state_t;

  state_t state;

  // memories
  nrlc_pkg::rect_t             rect_mem  [MAX_RECTS];
  logic [CW-1:0]               bl_mem    [MAX_RECTS];
  logic [AW-1:0]               succ_mem  [MAX_RECTS];
  logic [nrlc_pkg::NUM_W-1:0]  chain_mem [MAX_RECTS];

  nrlc_pkg::rect_t             rect_rd;
  logic [CW-1:0]               bl_rd;
  logic [AW-1:0]               succ_rd;
  logic [nrlc_pkg::NUM_W-1:0]  chain_rd;

  logic [AW-1:0]               ra;
  logic                        rect_we;
  logic [AW-1:0]               rect_wa;
  nrlc_pkg::rect_t             rect_wd;
  logic                        bl_we;
  logic [CW-1:0]               bl_wd;
  logic [AW-1:0]               succ_wd;
  logic                        chain_we;
  logic                        chain_re;

  // control registers
  logic [CW-1:0]               count;
  logic                        ovf;
  logic                        fin;
  nrlc_pkg::rect_t             key;
  logic [AW-1:0]               j;
  logic [AW-1:0]               p;
  logic [CW-1:0]               i;
  logic [nrlc_pkg::DIM_W-1:0]  pw;
  logic [nrlc_pkg::DIM_W-1:0]  ph;
  logic [CW-1:0]               cur_bl;
  logic [AW-1:0]               cur_succ;
  logic [CW-1:0]               max_bl;
  logic [AW-1:0]               start;
  logic [CW-1:0]               k;
  logic [AW-1:0]               pos;
  logic [CW-1:0]               len;
  logic [AW-1:0]               idx;
  logic                        out_valid;

  logic                        key_first;
  logic                        take;
  logic [CW-1:0]               nb;
  logic [AW-1:0]               ns;
  logic                        i_last;
  logic                        p_alone;
  logic [CW-1:0]               p_ext;
  logic [CW-1:0]               k_m1;
  logic                        slot_free;
  logic                        idx_last;
  logic                        out_load;

  assign p_ext     = CW'(p);
  assign k_m1      = k - 1'b1;
  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;
  assign q_re      = (state == S_IDLE) && !qstat.empty;
  assign idx_last  = (CW'(idx) + 1'b1 == len);
  assign out_load  = ((state == S_EM_LEN) || (state == S_EM_WR)) && slot_free;

  // stable order: new key moves down only past strictly smaller entries
  assign key_first = (key.h > rect_rd.h) || (key.h == rect_rd.h && key.w > rect_rd.w);
  assign take      = (rect_rd.h < ph) && (rect_rd.w < pw)
                     && ({1'b0, bl_rd} + 1'b1 > {1'b0, cur_bl});
  assign nb        = take ? bl_rd + 1'b1 : cur_bl;
  assign ns        = take ? i[AW-1:0] : cur_succ;
  assign i_last    = (i + 1'b1 == count);
  assign p_alone   = (p_ext + 1'b1 >= count);

  always_comb begin
    ra       = '0;
    rect_we  = 1'b0;
    rect_wa  = j;
    rect_wd  = key;
    bl_we    = 1'b0;
    bl_wd    = '0;
    succ_wd  = '0;
    chain_we = 1'b0;
    chain_re = 1'b0;
    unique case (state)
      S_INS_RD: begin
        if (j == '0) rect_we = 1'b1;
        else ra = j - 1'b1;
      end
      S_INS_CMP: begin
        rect_we = 1'b1;
        if (key_first) rect_wd = rect_rd;
      end
      S_DP_RDP:  ra = p;
      S_DP_LATP: begin
        ra = p + 1'b1;
        bl_we = p_alone;
      end
      S_DP_CMP: begin
        ra      = i[AW-1:0] + 1'b1;
        bl_we   = i_last;
        bl_wd   = nb;
        succ_wd = ns;
      end
      S_WK_RD:  ra = pos;
      S_WK_WR:  chain_we = 1'b1;
      S_EM_RD:  chain_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rect_we) rect_mem[rect_wa] <= rect_wd;
    rect_rd <= rect_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (bl_we) begin
      bl_mem[p]   <= bl_wd;
      succ_mem[p] <= succ_wd;
    end
    bl_rd   <= bl_mem[ra];
    succ_rd <= succ_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (chain_we) chain_mem[k_m1[AW-1:0]] <= rect_rd.num;
    if (chain_re) chain_rd <= chain_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            key <= q_word.r;
            fin <= q_word.fin;
            if (q_word.keep && count < CW'(MAX_RECTS)) begin
              j     <= count[AW-1:0];
              state <= S_INS_RD;
            end else begin
              if (q_word.keep) ovf <= 1'b1;
              if (q_word.fin) begin
                if (count == '0) begin
                  len   <= '0;
                  state <= S_EM_LEN;
                end else begin
                  p      <= AW'(count - 1'b1);
                  max_bl <= '0;
                  state  <= S_DP_RDP;
                end
              end
            end
          end
        end
        S_INS_RD, S_INS_CMP: begin
          if (state == S_INS_CMP && key_first) begin
            j     <= j - 1'b1;
            state <= S_INS_RD;
          end else if (state == S_INS_CMP || j == '0) begin
            count <= count + 1'b1;
            if (fin) begin
              p      <= count[AW-1:0];
              max_bl <= '0;
              state  <= S_DP_RDP;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_DP_RDP: state <= S_DP_LATP;
        S_DP_LATP: begin
          pw       <= rect_rd.w;
          ph       <= rect_rd.h;
          cur_bl   <= '0;
          cur_succ <= '0;
          i        <= p_ext + 1'b1;
          if (p_alone) begin
            if (max_bl == '0) start <= p;
            if (p == '0) state <= S_WK_SET;
            else begin
              p     <= p - 1'b1;
              state <= S_DP_RDP;
            end
          end else begin
            state <= S_DP_CMP;
          end
        end
        S_DP_CMP: begin
          cur_bl   <= nb;
          cur_succ <= ns;
          i        <= i + 1'b1;
          if (i_last) begin
            // later rows have smaller index, so >= keeps the first maximum
            if (nb >= max_bl) begin
              max_bl <= nb;
              start  <= p;
            end
            if (p == '0) state <= S_WK_SET;
            else begin
              p     <= p - 1'b1;
              state <= S_DP_RDP;
            end
          end
        end
        S_WK_SET: begin
          pos   <= start;
          len   <= max_bl + 1'b1;
          k     <= max_bl + 1'b1;
          state <= S_WK_RD;
        end
        S_WK_RD: state <= S_WK_WR;
        S_WK_WR: begin
          if (bl_rd == '0 || k == CW'(1)) state <= S_EM_LEN;
          else begin
            pos   <= succ_rd;
            k     <= k_m1;
            state <= S_WK_RD;
          end
        end
        S_EM_LEN: begin
          if (slot_free) begin
            value      <= nrlc_pkg::VAL_W'(len);
            is_length  <= 1'b1;
            run_end    <= (len == '0);
            overflowed <= ovf;
            if (len == '0) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              idx   <= '0;
              state <= S_EM_RD;
            end
          end
        end
        S_EM_RD: state <= S_EM_WR;
        S_EM_WR: begin
          if (slot_free) begin
            value      <= chain_rd;
            is_length  <= 1'b0;
            run_end    <= idx_last;
            overflowed <= ovf;
            if (idx_last) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_EM_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/nested_rectangle_longest_chain_top.sv =====
// ----------------------------------------------------------------------------
// nested_rectangle_longest_chain_top
// longest chain of strictly nested rectangles over one set of rectangles
// ----------------------------------------------------------------------------
// input side is a queue: a rectangle word is taken when push is high and full
// is low; final_item closes the set. rectangles are numbered from 1 and kept
// only when both sides exceed the card (cfg index 0 width, 1 height, written
// through cfg_valid/cfg_ready, ready always high).
// a four-word queue decouples the front from the back, so words keep being
// taken while the back is busy or a result waits.
// the back drops a rectangle that is not kept; a kept one is sorted into the
// store. on the final word it runs the chain search over the store memory,
// one pair compare per cycle, then walks the chain and writes its numbers,
// then gives the length result and the chain number results.
// results: length word first, then the chain numbers smallest to largest;
// a result sits on the ports while empty is low and leaves on pop. when
// the receiver stalls the back holds, then the queue fills and full rises.
// reset (synchronous, rst) empties the queue and the store and clears the
// card registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nested_rectangle_longest_chain_top #(
  parameter int MAX_RECTS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [nrlc_pkg::DIM_W-1:0]     rect_width,
  input  logic [nrlc_pkg::DIM_W-1:0]     rect_height,
  input  logic                           final_item,
  output logic                           empty,
  input  logic                           pop,
  output logic [nrlc_pkg::VAL_W-1:0]     value,
  output logic                           is_length,
  output logic                           run_end,
  output logic                           overflowed,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nrlc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [nrlc_pkg::DIM_W-1:0]     cfg_data
);

  nrlc_pkg::qstat_t qstat;
  nrlc_pkg::qword_t wr_word;
  nrlc_pkg::qword_t rd_word;
  logic             q_we;
  logic             q_re;

  assign full      = qstat.full;
  assign cfg_ready = 1'b1;

  nrlc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .qstat       (qstat),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .final_item  (final_item),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_we        (q_we),
    .q_word      (wr_word)
  );

  nrlc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .we    (q_we),
    .wdata (wr_word),
    .re    (q_re),
    .rdata (rd_word),
    .stat  (qstat)
  );

  nrlc_back #(
    .MAX_RECTS (MAX_RECTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .q_word     (rd_word),
    .q_re       (q_re),
    .empty      (empty),
    .pop        (pop),
    .value      (value),
    .is_length  (is_length),
    .run_end    (run_end),
    .overflowed (overflowed)
  );

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    q_we |-> !qstat.full) else $error("queue written while full");

  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    q_re |-> !qstat.empty) else $error("queue read while empty");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_length && !run_end) |-> value != '0)
    else $error("zero length with chain words following");

  a_len_zero_ends: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_length && run_end) |-> value == '0)
    else $error("nonzero length closes the run");

endmodule

// ===== verif/tb_nested_rectangle_longest_chain_top.sv =====
// ----------------------------------------------------------------------------
// tb_nested_rectangle_longest_chain_top
// self-checking bench for the nested rectangle longest chain block
// ----------------------------------------------------------------------------
// a queue of pending words (rectangles and card writes) feeds a clocked driver
// that also predicts the chain words of every accepted rectangle; a clocked
// monitor pops result words and compares them with the oldest prediction.
// card writes wait until the block is drained and has settled.
// ----------------------------------------------------------------------------
module tb_nested_rectangle_longest_chain_top;

  localparam int MAXR      = 32;
  localparam int SETTLE    = 400;
  localparam int WDOG_MAX  = 40000;
  localparam logic [nrlc_pkg::DIM_W-1:0] DIM_MAX = '1;

  typedef enum logic {OP_RECT, OP_CFG} op_kind_t;

  typedef struct {
    op_kind_t                   kind;
    logic [nrlc_pkg::DIM_W-1:0] w;
    logic [nrlc_pkg::DIM_W-1:0] h;
    logic                       fin;
    logic [nrlc_pkg::IDX_W-1:0] idx;
    logic                       drain;
    int                         phase;
  } op_t;

  typedef struct {
    logic [nrlc_pkg::VAL_W-1:0] val;
    logic                       is_len;
    logic                       last;
    logic                       ovf;
  } chain_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0, full, empty, pop = 1'b0;
  logic [nrlc_pkg::DIM_W-1:0] rect_width = '0, rect_height = '0;
  logic final_item = 1'b0;
  logic [nrlc_pkg::VAL_W-1:0] value;
  logic is_length, run_end, overflowed;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [nrlc_pkg::IDX_W-1:0] cfg_index = '0;
  logic [nrlc_pkg::DIM_W-1:0] cfg_data = '0;

  nested_rectangle_longest_chain_top #(.MAX_RECTS(MAXR)) i_dut (
    .clk, .rst, .push, .full, .rect_width, .rect_height, .final_item,
    .empty, .pop, .value, .is_length, .run_end, .overflowed,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #6 clk = ~clk;

  op_t         pending_q[$];
  chain_word_t chain_words_q[$];
  int errors = 0, n_rects = 0, n_words = 0, n_sets = 0, n_ovf_sets = 0;
  int settle_cnt = 0, tx_idle = 6, rx_idle = 65, wdog = 0;
  op_t cur;

  // predictor state
  logic [nrlc_pkg::DIM_W-1:0] card_w = '0, card_h = '0;
  logic [nrlc_pkg::DIM_W-1:0] st_w[MAXR];
  logic [nrlc_pkg::DIM_W-1:0] st_h[MAXR];
  logic [nrlc_pkg::NUM_W-1:0] st_num[MAXR];
  int st_cnt = 0;
  logic [nrlc_pkg::NUM_W-1:0] arrivals = '0;
  logic ovf_flag = 1'b0;

  function automatic void push_word(logic [nrlc_pkg::VAL_W-1:0] v, logic l, logic e);
    chain_word_t cw;
    cw.val = v; cw.is_len = l; cw.last = e; cw.ovf = ovf_flag;
    chain_words_q = {chain_words_q, cw};
  endfunction

  function automatic void predict_chain(logic [nrlc_pkg::DIM_W-1:0] w,
                                        logic [nrlc_pkg::DIM_W-1:0] h, logic fin);
    int best[MAXR];
    int succ[MAXR];
    int j, start, len, pos;
    logic [nrlc_pkg::DIM_W-1:0] tw, th;
    logic [nrlc_pkg::NUM_W-1:0] tn;
    logic [nrlc_pkg::VAL_W-1:0] nums[$];
    if (arrivals != nrlc_pkg::NUM_MAX) arrivals++;
    if (w > card_w && h > card_h) begin
      if (st_cnt < MAXR) begin
        st_w[st_cnt] = w; st_h[st_cnt] = h; st_num[st_cnt] = arrivals;
        st_cnt++;
      end else begin
        ovf_flag = 1'b1;
      end
    end
    if (!fin) return;
    n_sets++;
    if (ovf_flag) n_ovf_sets++;
    if (st_cnt == 0) begin
      push_word('0, 1'b1, 1'b1);
    end else begin
      // stable insertion sort, height then width, descending
      for (int i = 1; i < st_cnt; i++) begin
        tw = st_w[i]; th = st_h[i]; tn = st_num[i]; j = i;
        while (j > 0 && (th != st_h[j-1] ? th > st_h[j-1] : tw > st_w[j-1])) begin
          st_w[j] = st_w[j-1]; st_h[j] = st_h[j-1]; st_num[j] = st_num[j-1];
          j--;
        end
        st_w[j] = tw; st_h[j] = th; st_num[j] = tn;
      end
      for (int p = st_cnt - 1; p >= 0; p--) begin
        best[p] = 0; succ[p] = 0;
        for (int i = p + 1; i < st_cnt; i++)
          if (st_h[i] < st_h[p] && st_w[i] < st_w[p] && best[i] + 1 > best[p]) begin
            best[p] = best[i] + 1; succ[p] = i;
          end
      end
      start = 0;
      for (int i = 1; i < st_cnt; i++) if (best[i] > best[start]) start = i;
      len = best[start] + 1;
      push_word(len[nrlc_pkg::VAL_W-1:0], 1'b1, 1'b0);
      // walk from the largest; words go out smallest first
      pos = start;
      for (int k = 0; k < len; k++) begin
        nums.push_front(st_num[pos]);
        pos = succ[pos];
      end
      foreach (nums[k]) push_word(nums[k], 1'b0, k == len - 1);
    end
    st_cnt = 0; arrivals = '0; ovf_flag = 1'b0;
  endfunction

  // driver
  always @(posedge clk) begin
    logic nxt_push, nxt_cfg;
    if (rst) begin
      push <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_push = push;
      nxt_cfg = cfg_valid;
      if (push && !full) begin
        predict_chain(cur.w, cur.h, cur.fin);
        n_rects++;
        nxt_push = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cur.idx == nrlc_pkg::REG_CARD_WIDTH) card_w = cur.w;
        else if (cur.idx == nrlc_pkg::REG_CARD_HEIGHT) card_h = cur.w;
        nxt_cfg = 1'b0;
      end
      if (chain_words_q.size() == 0 && !nxt_push) settle_cnt++;
      else settle_cnt = 0;
      if (!nxt_push && !nxt_cfg && pending_q.size() > 0) begin
        tx_idle = pending_q[0].phase == 0 ? 6 : pending_q[0].phase == 1 ? 65 : 0;
        rx_idle = pending_q[0].phase == 0 ? 65 : pending_q[0].phase == 1 ? 6 : 0;
        if (pending_q[0].kind == OP_CFG ? settle_cnt >= SETTLE :
            (!pending_q[0].drain || chain_words_q.size() == 0) &&
            $urandom_range(99) >= tx_idle) begin
          cur = pending_q.pop_front();
          if (cur.kind == OP_CFG) begin
            nxt_cfg = 1'b1;
            cfg_index <= cur.idx;
            cfg_data <= cur.w;
          end else begin
            nxt_push = 1'b1;
            rect_width <= cur.w;
            rect_height <= cur.h;
            final_item <= cur.fin;
          end
        end
      end
      push <= nxt_push;
      cfg_valid <= nxt_cfg;
    end
  end

  // monitor
  always @(posedge clk) begin
    chain_word_t cw;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_words++;
        if (chain_words_q.size() == 0) begin
          $error("unexpected result word value=%0d", value);
          errors++;
        end else begin
          cw = chain_words_q.pop_front();
          if (value !== cw.val) begin
            $error("value: expected %0d, got %0d", cw.val, value); errors++;
          end
          if (is_length !== cw.is_len) begin
            $error("is_length: expected %0b, got %0b", cw.is_len, is_length); errors++;
          end
          if (run_end !== cw.last) begin
            $error("run_end: expected %0b, got %0b", cw.last, run_end); errors++;
          end
          if (overflowed !== cw.ovf) begin
            $error("overflowed: expected %0b, got %0b", cw.ovf, overflowed); errors++;
          end
        end
      end
      pop <= $urandom_range(99) >= rx_idle;
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("FAIL nested_rectangle_longest_chain_top");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  function automatic void add_rect(logic [nrlc_pkg::DIM_W-1:0] w,
                                   logic [nrlc_pkg::DIM_W-1:0] h,
                                   logic fin, int ph, logic drain = 1'b0);
    op_t o;
    o.kind = OP_RECT; o.w = w; o.h = h; o.fin = fin; o.idx = '0;
    o.drain = drain; o.phase = ph;
    pending_q = {pending_q, o};
  endfunction

  function automatic void add_cfg(logic [nrlc_pkg::IDX_W-1:0] idx,
                                  logic [nrlc_pkg::DIM_W-1:0] d, int ph);
    op_t o;
    o.kind = OP_CFG; o.w = d; o.h = '0; o.fin = 1'b0; o.idx = idx;
    o.drain = 1'b0; o.phase = ph;
    pending_q = {pending_q, o};
  endfunction

  function automatic logic [nrlc_pkg::DIM_W-1:0] rand_dim();
    if ($urandom_range(9) == 0) return nrlc_pkg::DIM_W'($urandom);
    return nrlc_pkg::DIM_W'($urandom_range(0, 24));
  endfunction

  initial begin
    int ph, sz, total;
    // directed: extremes, empty set, ties, overflow, ignored indexes
    add_rect('0, '0, 1'b1, 0);
    add_rect(DIM_MAX, DIM_MAX, 1'b0, 0);
    add_rect(3, 3, 1'b0, 0);
    add_rect(3, 3, 1'b0, 0);
    add_rect(5, 2, 1'b0, 0);
    add_rect(2, 5, 1'b0, 0);
    add_rect(1, 1, 1'b1, 0);
    add_cfg(nrlc_pkg::REG_CARD_WIDTH, DIM_MAX, 0);
    add_cfg(nrlc_pkg::REG_CARD_HEIGHT, DIM_MAX, 0);
    add_rect(DIM_MAX, DIM_MAX, 1'b1, 0);
    add_cfg(nrlc_pkg::REG_CARD_WIDTH, 2, 0);
    add_cfg(nrlc_pkg::REG_CARD_HEIGHT, 0, 0);
    add_cfg(2'd2, DIM_MAX, 0);
    add_cfg(2'd3, DIM_MAX, 0);
    for (int i = 0; i < 36; i++)
      add_rect(nrlc_pkg::DIM_W'(40 - i), nrlc_pkg::DIM_W'(i % 7 + 1), i == 35, 0);
    add_cfg(nrlc_pkg::REG_CARD_WIDTH, 0, 0);
    // random sets over three idling phases
    total = 0;
    while (total < 420) begin
      ph = total < 140 ? 0 : total < 280 ? 1 : 2;
      if ($urandom_range(3) == 0) begin
        add_cfg(nrlc_pkg::REG_CARD_WIDTH, $urandom_range(4) == 0 ?
                nrlc_pkg::DIM_W'($urandom) : nrlc_pkg::DIM_W'($urandom_range(0, 6)), ph);
        add_cfg(nrlc_pkg::REG_CARD_HEIGHT, $urandom_range(4) == 0 ?
                nrlc_pkg::DIM_W'($urandom) : nrlc_pkg::DIM_W'($urandom_range(0, 6)), ph);
      end
      sz = $urandom_range(19) == 0 ? $urandom_range(33, 40) : $urandom_range(1, 12);
      for (int i = 0; i < sz; i++)
        add_rect(rand_dim(), rand_dim(), i == sz - 1, ph,
                 i == 0 && $urandom_range(7) == 0);
      total += sz;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0 && !push && !cfg_valid && chain_words_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d rectangles in %0d sets (%0d overflowed), %0d result words",
             n_rects, n_sets, n_ovf_sets, n_words);
    if (errors == 0 && chain_words_q.size() == 0) begin
      $display("PASS nested_rectangle_longest_chain_top");
    end else begin
      $display("FAIL nested_rectangle_longest_chain_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/nrlc_pkg.sv
design/nrlc_front.sv
design/nrlc_fifo.sv
design/nrlc_back.sv
design/nested_rectangle_longest_chain_top.sv
verif/tb_nested_rectangle_longest_chain_top.sv
